@@ rtl/core/ir_pulse_width_receiver_unit_defines.svh @@
// assertion helpers for the ir pulse width receiver
`ifndef IR_PULSE_WIDTH_RECEIVER_UNIT_DEFINES_SVH
`define IR_PULSE_WIDTH_RECEIVER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define IPWR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ipwr assertion failed");

// next-cycle implication, checked out of reset
`define IPWR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ipwr assertion failed");

`endif

@@ rtl/core/ipwr_pkg.sv @@
package ipwr_pkg;

  localparam int RX_BITS_DEF     = 32;
  localparam int COUNTER_MAX_DEF = 4095;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN   = 3'd5;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_DONE  = 2'd1,
    EV_ERROR = 2'd2
  } event_t;

  localparam logic [9:0] START_RST = 10'd96;
  localparam logic [9:0] ONE_RST   = 10'd48;
  localparam logic [8:0] ZERO_RST  = 9'd24;
  localparam logic [9:0] SPACE_RST = 10'd24;
  localparam logic [7:0] TOL_RST   = 8'd8;
  localparam logic [5:0] MIN_RST   = 6'd13;

endpackage

@@ rtl/core/ir_pulse_width_receiver_unit.sv @@
// Pulse-width IR receiver. One line sample (ir_level, 0 = carrier present) is taken
// per word on the input channel and exactly one result word follows it in the next
// cycle, from the result register; a new sample can be taken every cycle when not
// stalled, so the block then sustains one sample per clock. The input stalls
// only while a result sits unread and the output side stalls. Low and high tick
// counters saturate at COUNTER_MAX; each edge checks the measured length against
// the start, zero, one or space window (strictly inside nominal +/- tolerance),
// and a high time above eight zero widths ends an open packet. Configuration is
// written through cfg_valid/cfg_ready (always ready) at indexes start, one, zero,
// space, tolerance, min_bits; write only while the block is idle.
`include "ir_pulse_width_receiver_unit_defines.svh"

module ir_pulse_width_receiver_unit #(
  parameter int RX_BITS     = ipwr_pkg::RX_BITS_DEF,
  parameter int COUNTER_MAX = ipwr_pkg::COUNTER_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            ir_level,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      event_res,
  output logic [5:0]                      bit_total,
  output logic [31:0]                     packet_bits,
  output logic                            in_packet,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ipwr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipwr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ipwr_pkg::*;

  localparam int CW        = $clog2(COUNTER_MAX + 1);
  localparam int WW        = ((CW > 11) ? CW : 11) + 1;
  localparam int TW        = ((CW > 12) ? CW : 12) + 1;
  localparam int STORE_LIM = (RX_BITS < 32) ? RX_BITS : 32;
  localparam int COUNT_CAP = (RX_BITS > 63) ? 63 : RX_BITS;

  localparam logic [CW-1:0] CNT_MAX  = CW'(COUNTER_MAX);
  localparam logic [5:0]    CAP      = 6'(COUNT_CAP);
  localparam logic [6:0]    STORE_TOP = 7'(STORE_LIM);

  // config registers
  logic [9:0] start_width;
  logic [9:0] one_width;
  logic [8:0] zero_width;
  logic [9:0] space_width;
  logic [7:0] tolerance;
  logic [5:0] min_bits;

  // receiver state
  logic          prev_level;
  logic [CW-1:0] low_ticks;
  logic [CW-1:0] high_ticks;
  logic          receiving;
  logic [5:0]    bit_count;
  logic [31:0]   bit_store;

  logic          prev_level_next;
  logic [CW-1:0] low_ticks_next;
  logic [CW-1:0] high_ticks_next;
  logic          receiving_next;
  logic [5:0]    bit_count_next;
  logic [31:0]   bit_store_next;
  event_t        event_next;

  event_t        event_q;
  logic          accept;

  function automatic logic in_window(input logic [CW-1:0] count, input logic [9:0] nominal,
                                     input logic [7:0] tol);
    logic [WW-1:0] c;
    logic [WW-1:0] n;
    logic [WW-1:0] t;
    c = WW'(count);
    n = WW'(nominal);
    t = WW'(tol);
    return (c < n + t) && (c + t > n);
  endfunction

  function automatic void append(input logic value, input logic [5:0] cnt,
                                 inout logic [31:0] store, output logic [5:0] cnt_out);
    if ((7'(cnt) < STORE_TOP) && value) begin
      store[cnt[4:0]] = 1'b1;
    end
    cnt_out = (cnt < CAP) ? cnt + 6'd1 : cnt;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_width <= START_RST;
      one_width   <= ONE_RST;
      zero_width  <= ZERO_RST;
      space_width <= SPACE_RST;
      tolerance   <= TOL_RST;
      min_bits    <= MIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_START: start_width <= cfg_data;
        CFG_ONE:   one_width   <= cfg_data;
        CFG_ZERO:  zero_width  <= cfg_data[8:0];
        CFG_SPACE: space_width <= cfg_data;
        CFG_TOL:   tolerance   <= cfg_data[7:0];
        CFG_MIN:   min_bits    <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prev_level_next = ir_level;
    low_ticks_next  = low_ticks;
    high_ticks_next = high_ticks;
    receiving_next  = receiving;
    bit_count_next  = bit_count;
    bit_store_next  = bit_store;
    event_next      = EV_NONE;

    if (ir_level != prev_level) begin
      if (!ir_level) begin
        if (receiving && !in_window(high_ticks, space_width, tolerance)) begin
          receiving_next = 1'b0;
          bit_count_next = '0;
          bit_store_next = '0;
          event_next     = EV_ERROR;
        end
      end else if (receiving) begin
        if (in_window(low_ticks, {1'b0, zero_width}, tolerance)) begin
          append(1'b0, bit_count, bit_store_next, bit_count_next);
        end else if (in_window(low_ticks, one_width, tolerance)) begin
          append(1'b1, bit_count, bit_store_next, bit_count_next);
        end else begin
          receiving_next = 1'b0;
          bit_count_next = '0;
          bit_store_next = '0;
          event_next     = EV_ERROR;
        end
      end else if (in_window(low_ticks, start_width, tolerance)) begin
        bit_count_next = '0;
        bit_store_next = '0;
        receiving_next = 1'b1;
      end
      low_ticks_next  = '0;
      high_ticks_next = '0;
    end else if (!ir_level) begin
      if (low_ticks != CNT_MAX) low_ticks_next = low_ticks + CW'(1);
    end else begin
      if (high_ticks != CNT_MAX) high_ticks_next = high_ticks + CW'(1);
    end

    // timeout after a long high
    if (ir_level && receiving_next &&
        (TW'(high_ticks_next) > TW'({zero_width, 3'b000}))) begin
      receiving_next = 1'b0;
      event_next     = (bit_count_next >= min_bits) ? EV_DONE : EV_ERROR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level <= 1'b1;
      low_ticks  <= '0;
      high_ticks <= '0;
      receiving  <= 1'b0;
      bit_count  <= '0;
      bit_store  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        prev_level <= prev_level_next;
        low_ticks  <= low_ticks_next;
        high_ticks <= high_ticks_next;
        receiving  <= receiving_next;
        bit_count  <= bit_count_next;
        bit_store  <= bit_store_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (accept) begin
      event_q <= event_next;
    end
  end

  assign event_res   = event_q;
  assign bit_total   = bit_count;
  assign packet_bits = bit_store;
  assign in_packet   = receiving;

  `IPWR_ASSERT_NEXT(a_accept_gives_word, accept, out_valid)
  `IPWR_ASSERT_NOW(a_done_closes_packet, out_valid && (event_q == EV_DONE), !in_packet)
  `IPWR_ASSERT_NOW(a_count_capped, out_valid, bit_total <= CAP)
  `IPWR_ASSERT_NOW(a_store_limit, out_valid, (packet_bits >> STORE_LIM) == 32'd0)

endmodule

@@ verif/tb.sv @@
module tb;
  import ipwr_pkg::*;

  localparam int RX_BITS = RX_BITS_DEF;
  localparam int CNT_MAX = COUNTER_MAX_DEF;
  localparam int NBITS_CAP = (RX_BITS > 63) ? 63 : RX_BITS;
  localparam int TIMEOUT_MUL = 8;
  localparam int CYCLE_LIMIT = 250000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef struct packed {
    event_t      ev;
    logic [5:0]  total;
    logic [31:0] bits;
    logic        open;
  } rx_status_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic                  ir_level;
  logic                  out_valid;
  logic                  out_stall;
  logic [1:0]            event_res;
  logic [5:0]            bit_total;
  logic [31:0]           packet_bits;
  logic                  in_packet;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // receiver settings as last written
  logic [9:0] start_w, one_w, space_w;
  logic [8:0] zero_w;
  logic [7:0] tol;
  logic [5:0] min_nbits;

  // decoder state
  logic        last_level;
  logic [11:0] low_cnt, high_cnt;
  logic        rx_open;
  logic [5:0]  nbits;
  logic [31:0] rx_bits;

  bit         line_samples[$];
  rx_status_t rx_status_q[$];
  rx_status_t due;
  int         tx_idle_pct, rx_idle_pct;
  int         mismatches = 0;
  int         cycles = 0;

  ir_pulse_width_receiver_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .ir_level    (ir_level),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_res   (event_res),
    .bit_total   (bit_total),
    .packet_bits (packet_bits),
    .in_packet   (in_packet),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit in_window(int cnt, int nominal);
    return (cnt < nominal + int'(tol)) && (cnt > nominal - int'(tol));
  endfunction

  function automatic void drop_packet();
    rx_open = 1'b0;
    nbits = '0;
    rx_bits = '0;
  endfunction

  function automatic void add_bit(bit b);
    if (nbits < RX_BITS && nbits < 32 && b) rx_bits[nbits[4:0]] = 1'b1;
    if (nbits < NBITS_CAP) nbits = nbits + 6'd1;
  endfunction

  function automatic rx_status_t decode_sample(bit lvl);
    rx_status_t w;
    event_t     ev;
    ev = EV_NONE;
    if (lvl != last_level) begin
      if (!lvl) begin
        if (rx_open && !in_window(int'(high_cnt), int'(space_w))) begin
          drop_packet();
          ev = EV_ERROR;
        end
      end else if (rx_open) begin
        if (in_window(int'(low_cnt), int'(zero_w))) add_bit(1'b0);
        else if (in_window(int'(low_cnt), int'(one_w))) add_bit(1'b1);
        else begin
          drop_packet();
          ev = EV_ERROR;
        end
      end else if (in_window(int'(low_cnt), int'(start_w))) begin
        nbits = '0;
        rx_bits = '0;
        rx_open = 1'b1;
      end
      low_cnt = '0;
      high_cnt = '0;
    end else if (!lvl) begin
      if (low_cnt < CNT_MAX) low_cnt = low_cnt + 12'd1;
    end else if (high_cnt < CNT_MAX) begin
      high_cnt = high_cnt + 12'd1;
    end
    last_level = lvl;
    // long high ends the packet
    if (lvl && rx_open && int'(high_cnt) > TIMEOUT_MUL * int'(zero_w)) begin
      rx_open = 1'b0;
      ev = (nbits >= min_nbits) ? EV_DONE : EV_ERROR;
    end
    w.ev = ev;
    w.total = nbits;
    w.bits = rx_bits;
    w.open = rx_open;
    return w;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) rx_status_q.push_back(decode_sample(ir_level));
      if (!in_valid || !in_stall) begin
        if (line_samples.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          in_valid <= 1'b1;
          ir_level <= line_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      if (out_valid && !out_stall) begin
        if (rx_status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: unexpected result word", $time);
        end else begin
          due = rx_status_q.pop_front();
          if (event_res !== due.ev || bit_total !== due.total ||
              packet_bits !== due.bits || in_packet !== due.open) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: event %0d/%0d count %0d/%0d bits %h/%h open %0b/%0b (exp/got)",
                       $time, due.ev, event_res, due.total, bit_total, due.bits, packet_bits,
                       due.open, in_packet);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_START: start_w = val;
      CFG_ONE:   one_w = val;
      CFG_ZERO:  zero_w = val[8:0];
      CFG_SPACE: space_w = val;
      CFG_TOL:   tol = val[7:0];
      CFG_MIN:   min_nbits = val[5:0];
      default: ;
    endcase
  endtask

  task automatic set_timing(logic [9:0] s, logic [9:0] o, logic [9:0] z, logic [9:0] sp,
                            logic [9:0] t, logic [9:0] m);
    write_reg(CFG_START, s);
    write_reg(CFG_ONE, o);
    write_reg(CFG_ZERO, z);
    write_reg(CFG_SPACE, sp);
    write_reg(CFG_TOL, t);
    write_reg(CFG_MIN, m);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (line_samples.size() != 0 || in_valid || rx_status_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic void push_run(bit lvl, int n);
    for (int k = 0; k < n; k++) line_samples.push_back(lvl);
  endfunction

  // counter value that a mark should reach, mostly inside the window
  function automatic int near(int nominal, bit sloppy);
    int t;
    int v;
    t = tol;
    case (sloppy ? $urandom_range(0, 5) : 5)
      0: v = nominal + ($urandom_range(0, 1) ? t : -t);
      1: v = int'($urandom_range(0, 2 * nominal + t + 2));
      default: v = (t > 0) ? nominal - (t - 1) + int'($urandom_range(0, 2 * t - 2)) : nominal;
    endcase
    return (v < 0) ? 0 : v;
  endfunction

  function automatic void gen_packet(int max_nbits);
    int n;
    int lo;
    bit sloppy;
    sloppy = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 6))
        push_run(1'($urandom_range(0, 1)), $urandom_range(1, start_w + tol + 2));
    push_run(1'b1, $urandom_range(1, 4));
    push_run(1'b0, near(start_w, sloppy) + 1);
    lo = (min_nbits > 2) ? int'(min_nbits) - 2 : 0;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(lo, min_nbits + 3);
    if (n > max_nbits) n = max_nbits;
    repeat (n) begin
      push_run(1'b1, near(space_w, sloppy) + 1);
      push_run(1'b0, near($urandom_range(0, 1) ? one_w : zero_w, sloppy) + 1);
    end
    push_run(1'b1, TIMEOUT_MUL * zero_w + $urandom_range(2, 5));
  endfunction

  function automatic void fill(int budget, int max_nbits);
    int goal;
    goal = line_samples.size() + budget;
    while (line_samples.size() < goal) gen_packet(max_nbits);
  endfunction

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    ir_level = 1'b1;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_START;
    cfg_data = '0;
    start_w = START_RST;
    one_w = ONE_RST;
    zero_w = ZERO_RST;
    space_w = SPACE_RST;
    tol = TOL_RST;
    min_nbits = MIN_RST;
    last_level = 1'b1;
    low_cnt = '0;
    high_cnt = '0;
    rx_open = 1'b0;
    nbits = '0;
    rx_bits = '0;
    tx_idle_pct = 37;
    rx_idle_pct = 54;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // short marks: start, zero, one, bad space, restart
    set_timing(10'd3, 10'd2, 10'd1, 10'd1, 10'd1, 10'd2);
    push_run(1'b1, 2);
    push_run(1'b0, 4);
    push_run(1'b1, 2);
    push_run(1'b0, 2);
    push_run(1'b1, 2);
    push_run(1'b0, 3);
    push_run(1'b1, 4);
    push_run(1'b0, 4);
    push_run(1'b1, 2);
    fill(80, 40);
    drain();

    set_timing(10'd12, 10'd8, 10'd4, 10'd4, 10'd2, 10'd6);
    fill(120, 40);
    drain();

    tx_idle_pct = 54;
    rx_idle_pct = 37;
    set_timing(10'd10, 10'd6, 10'd3, 10'd3, 10'd2, 10'd8);
    fill(150, 40);
    drain();

    // packets past the store size
    set_timing(10'd2, 10'd3, 10'd1, 10'd1, 10'd1, 10'd32);
    fill(150, 40);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // zero tolerance: no window can match
    set_timing(10'd1, 10'd1, 10'd1, 10'd1, 10'd0, 10'd0);
    fill(30, 40);
    drain();

    // widest settings and unused indexes
    set_timing(10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff);
    write_reg(CFG_SPARE_A, 10'h155);
    write_reg(CFG_SPARE_B, 10'h2aa);
    cfg_valid <= 1'b0;
    push_run(1'b1, 3);
    push_run(1'b0, 40);
    push_run(1'b1, 40);
    drain();

    repeat (4) @(posedge clk);
    if (mismatches == 0 && rx_status_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ ir_pulse_width_receiver_unit.f @@
+incdir+rtl/core
rtl/core/ipwr_pkg.sv
rtl/core/ir_pulse_width_receiver_unit.sv
verif/tb.sv
